// ===== rtl/three_lfsr_combiner_stream_cipher_assert.svh =====
// Assertion macros shared by the cipher checker.
`ifndef THREE_LFSR_COMBINER_STREAM_CIPHER_ASSERT_SVH
`define THREE_LFSR_COMBINER_STREAM_CIPHER_ASSERT_SVH

// Same-cycle implication, idle in reset.
`define TLFSR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlfsr check failed");

// Next-cycle implication, idle in reset.
`define TLFSR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlfsr check failed");

// Next-cycle implication that also holds through reset.
`define TLFSR_ASSERT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tlfsr check failed");

`endif

// ===== rtl/tlfsr_pkg.sv =====
// Shared types and constants of the three-LFSR combiner cipher.
package tlfsr_pkg;

  localparam int KEY_W       = 64;
  localparam int BYTE_W      = 8;
  localparam int CFG_INDEX_W = 4;

  localparam int LEN_A = 43;
  localparam int LEN_B = 41;
  localparam int LEN_C = 47;

  localparam logic [LEN_A-1:0] TAPS_A = 43'h332B;
  localparam logic [LEN_B-1:0] TAPS_B = 41'h2D;
  localparam logic [LEN_C-1:0] TAPS_C = 47'h69;

  // Boolean combiner tables, bit i is the entry for index i
  localparam logic [7:0] TAB_ONE   = 8'hE8;
  localparam logic [7:0] TAB_TWO   = 8'hD2;
  localparam logic [7:0] TAB_THREE = 8'hAC;

  // Register indexes on the config port
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 4'd1;

  typedef struct packed {
    logic [KEY_W-1:0] low;
    logic [KEY_W-1:0] high;
  } key_t;

endpackage

// ===== rtl/tlfsr_cfg.sv =====
// Key register file written through the config channel.
module tlfsr_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tlfsr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tlfsr_pkg::KEY_W-1:0]        cfg_data,
  output tlfsr_pkg::key_t                    key
);
  import tlfsr_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key.low  <= '0;
      key.high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_LOW:  key.low  <= cfg_data;
        REG_KEY_HIGH: key.high <= cfg_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule

// ===== rtl/tlfsr_core.sv =====
// LFSR state, key reload and eight-step keystream per byte.
module tlfsr_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic                          restart,
  input  logic [tlfsr_pkg::BYTE_W-1:0]  data_byte,
  input  tlfsr_pkg::key_t               key,
  output logic [tlfsr_pkg::BYTE_W-1:0]  result_byte
);
  import tlfsr_pkg::*;

  logic [LEN_A-1:0] lfsr_a, lfsr_a_next;
  logic [LEN_B-1:0] lfsr_b, lfsr_b_next;
  logic [LEN_C-1:0] lfsr_c, lfsr_c_next;
  logic [BYTE_W-1:0] ks;

  always_comb begin
    logic [LEN_A-1:0] a;
    logic [LEN_B-1:0] b;
    logic [LEN_C-1:0] c;
    logic [2:0]       idx;
    logic [47:0]      slice_b;
    if (restart) begin
      slice_b = {key.high[23:0], key.low[63:40]};  // key bytes 5..10
      a = key.low[LEN_A-1:0];
      b = slice_b[LEN_B+2:3];
      c = {3'b000, key.high[63:20]};               // key bytes 10..15 >> 4
    end else begin
      slice_b = '0;
      a = lfsr_a;
      b = lfsr_b;
      c = lfsr_c;
    end
    ks = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      idx   = {c[0], b[0], a[0]};
      ks[i] = TAB_ONE[idx] ^ TAB_TWO[idx] ^ TAB_THREE[idx];
      a = {^(a & TAPS_A), a[LEN_A-1:1]};
      b = {^(b & TAPS_B), b[LEN_B-1:1]};
      c = {^(c & TAPS_C), c[LEN_C-1:1]};
    end
    lfsr_a_next = a;
    lfsr_b_next = b;
    lfsr_c_next = c;
  end

  assign result_byte = data_byte ^ ks;

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr_a <= '0;
      lfsr_b <= '0;
      lfsr_c <= '0;
    end else if (fire) begin
      lfsr_a <= lfsr_a_next;
      lfsr_b <= lfsr_b_next;
      lfsr_c <= lfsr_c_next;
    end
  end

endmodule

// ===== rtl/three_lfsr_combiner_stream_cipher.sv =====
// Top level of the three-LFSR combiner stream cipher.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   s_*     | in        | s_tvalid / s_tready  | tdata = data_byte, tuser = restart
//   m_*     | out       | m_tvalid / m_tready  | tdata = result_byte
//   cfg_*   | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data (64-bit key word)
//
// One word per cycle sustained while m_tready stays high; an accepted word goes to the input
// register, then the eight unrolled LFSR steps and the XOR feed the output register,
// where m_tvalid rises. The LFSRs advance as the word moves on.
// Reset (rst, synchronous) zeroes LFSRs and key; until a restart word arrives the
// keystream is zero. A stall on m_tready holds the output and a full input register;
// s_tready drops only when both are full. cfg_ready is tied high; write keys while idle.
module three_lfsr_combiner_stream_cipher (
  input  logic                               clk,
  input  logic                               rst,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // [7:0] data_byte
  input  logic [0:0]                         s_tuser,   // [0] restart
  // output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [7:0]                         m_tdata,   // [7:0] result_byte
  // config writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tlfsr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tlfsr_pkg::KEY_W-1:0]        cfg_data
);
  import tlfsr_pkg::*;

  key_t              key;
  logic              in_valid;
  logic [BYTE_W-1:0] in_data;
  logic              in_restart;
  logic [BYTE_W-1:0] result_byte;
  logic              advance;
  logic              fire;

  // output slot free or draining this cycle
  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  tlfsr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  tlfsr_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .restart     (in_restart),
    .data_byte   (in_data),
    .key         (key),
    .result_byte (result_byte)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data    <= s_tdata;
      in_restart <= s_tuser[0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= result_byte;
    end
  end

endmodule

// ===== rtl/tlfsr_checker.sv =====
// Port-level checks for the cipher top level, with its bind.
`include "three_lfsr_combiner_stream_cipher_assert.svh"

module tlfsr_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [7:0]                         m_tdata
);

  // a stalled result word stays put
  `TLFSR_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // reset empties the output slot
  `TLFSR_ASSERT_ALWAYS(a_rst_empty, clk, rst, !m_tvalid)

  // with no result pending the input side cannot be blocked
  `TLFSR_ASSERT_NOW(a_ready_when_empty, clk, rst, !m_tvalid, s_tready)

  // an accepted word passes the input register and is in the output slot when the sink is ready in between
  `TLFSR_ASSERT_NEXT(a_latency, clk, rst, s_tvalid && s_tready ##1 m_tready, m_tvalid)

endmodule

bind three_lfsr_combiner_stream_cipher tlfsr_checker u_tlfsr_checker (.*);

// ===== test/tb_three_lfsr_combiner_stream_cipher.sv =====
// Self-checking testbench of the three-LFSR combiner stream cipher, with a keystream scoreboard.
module tb_three_lfsr_combiner_stream_cipher;
  import tlfsr_pkg::*;

  localparam int IDLE_PCT     = 21;    // percent of cycles a side sits idle
  localparam int HOLD_CYCLES  = 60;    // long receiver hold-off
  localparam int DRAIN_CYCLES = 2;     // extra idle cycles after the last predicted byte
  localparam int STALL_LIMIT  = 1000;  // cycles with no handshake before giving up
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_WORDS  = 90;

  // Key load slices: six key bytes as a 48-bit word, then shifted down.
  localparam int SLICE_W     = 48;
  localparam int SLICE_B_LSB = 40;     // key byte 5
  localparam int SLICE_C_LSB = 80;     // key byte 10
  localparam int SHIFT_B     = 3;
  localparam int SHIFT_C     = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = REG_KEY_HIGH + 1'b1;
  localparam logic [CFG_INDEX_W-1:0] REG_LAST_UNUSED  = '1;

  typedef enum int {KEY_RANDOM, KEY_ONES, KEY_ZERO, KEY_ONE_HOT, KEY_STRIPES} key_style_t;

  // Holds the key and the three shift registers, predicts each output byte.
  class keystream_scoreboard;
    logic [KEY_W-1:0] key_low;
    logic [KEY_W-1:0] key_high;
    logic [LEN_A-1:0] lfsr_a;
    logic [LEN_B-1:0] lfsr_b;
    logic [LEN_C-1:0] lfsr_c;
    logic [BYTE_W-1:0] expected_bytes[$];
    int errors;

    function new();
      key_low  = '0;
      key_high = '0;
      lfsr_a   = '0;
      lfsr_b   = '0;
      lfsr_c   = '0;
      errors   = 0;
    endfunction

    function void write_key(logic [CFG_INDEX_W-1:0] idx, logic [KEY_W-1:0] value);
      // indexes past the two key words are dropped
      if (idx == REG_KEY_LOW) key_low = value;
      else if (idx == REG_KEY_HIGH) key_high = value;
    endfunction

    function void reload();
      logic [2*KEY_W-1:0] key_all;
      logic [SLICE_W-1:0] slice;
      key_all = {key_high, key_low};
      lfsr_a  = key_all[LEN_A-1:0];
      slice   = key_all[SLICE_B_LSB +: SLICE_W];
      lfsr_b  = slice[SHIFT_B +: LEN_B];
      // top slice leaves the upper three bits of C empty
      slice   = key_all[SLICE_C_LSB +: SLICE_W];
      lfsr_c  = LEN_C'(slice >> SHIFT_C);
    endfunction

    function logic [BYTE_W-1:0] keystream_byte();
      logic [BYTE_W-1:0] ks;
      logic [7:0] combined;
      logic [2:0] idx;
      int i;
      combined = TAB_ONE ^ TAB_TWO ^ TAB_THREE;
      for (i = 0; i < BYTE_W; i++) begin
        idx    = {lfsr_c[0], lfsr_b[0], lfsr_a[0]};
        ks[i]  = combined[idx];
        lfsr_a = {^(lfsr_a & TAPS_A), lfsr_a[LEN_A-1:1]};
        lfsr_b = {^(lfsr_b & TAPS_B), lfsr_b[LEN_B-1:1]};
        lfsr_c = {^(lfsr_c & TAPS_C), lfsr_c[LEN_C-1:1]};
      end
      return ks;
    endfunction

    function void accept_byte(logic [BYTE_W-1:0] data, logic restart);
      if (restart) reload();
      expected_bytes.push_back(data ^ keystream_byte());
    endfunction

    function void check_byte(logic [BYTE_W-1:0] actual);
      logic [BYTE_W-1:0] want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result_byte, expected none, actual %h", $time, actual);
      end else begin
        want = expected_bytes.pop_front();
        if (actual !== want) begin
          errors++;
          $display("%0t: result_byte mismatch, expected %h, actual %h", $time, want, actual);
        end
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [7:0]             s_tdata;
  logic [0:0]             s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [7:0]             m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [KEY_W-1:0]       cfg_data;

  keystream_scoreboard sb = new();

  bit gaps_on = 1'b1;   // cleared for a stretch with no idling on either side
  bit hold_rx = 1'b0;   // asks the receiver for one long hold-off
  int stall_cycles = 0;

  three_lfsr_combiner_stream_cipher u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitors sample pre-edge values, so handshakes are seen exactly as the block sees them.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_key(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.accept_byte(s_tdata, s_tuser[0]);
      if (m_tvalid && m_tready) sb.check_byte(m_tdata);
    end
  end

  // Watchdog: any handshake resets the count.
  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end else begin
        m_tready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // One config word; valid drops after each write and is held low over an idle edge.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [KEY_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_key_pair(input logic [KEY_W-1:0] low, input logic [KEY_W-1:0] high);
    write_reg(REG_KEY_LOW, low);
    write_reg(REG_KEY_HIGH, high);
  endtask

  task automatic write_unused_reg();
    write_reg(CFG_INDEX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
              {$urandom, $urandom});
  endtask

  // Offer one word; random idle cycles go before it, valid stays high after accept.
  task automatic send_byte(input logic [7:0] data, input logic restart);
    while (gaps_on && ($urandom_range(0, 99) < IDLE_PCT)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= restart;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted byte has come out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key(key_style_t style);
    case (style)
      KEY_ONES:    return '1;
      KEY_ZERO:    return '0;
      KEY_ONE_HOT: return KEY_W'(1) << $urandom_range(0, KEY_W - 1);
      KEY_STRIPES: return $urandom_range(0, 1) ? {16{4'h5}} : {16{4'hA}};
      default:     return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    key_style_t style;
    logic restart;
    int p;
    int n;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // No restart since reset: registers zero, bytes pass straight through.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    // Restart with the all-zero reset key keeps the keystream zero.
    send_byte(8'h3C, 1'b1);
    send_byte(8'h81, 1'b0);
    wait_drained();

    load_key_pair('1, '1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b0);
    wait_drained();

    // New key without restart: old stream continues until the next restart.
    load_key_pair({$urandom, $urandom}, {$urandom, $urandom});
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    wait_drained();

    // Write to an unused index must leave the key alone.
    write_unused_reg();
    send_byte(8'h00, 1'b1);
    send_byte(8'h7E, 1'b0);
    wait_drained();

    // Single-bit keys at both ends of the key, top one feeds only the C slice.
    load_key_pair(KEY_W'(1) << (KEY_W - 1), KEY_W'(1));
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    wait_drained();
    load_key_pair('0, KEY_W'(1) << (KEY_W - 1));
    send_byte(8'h00, 1'b1);
    send_byte(8'hC3, 1'b0);
    wait_drained();

    // Random phases, each with its own key.
    for (p = 0; p < NUM_PHASES; p++) begin
      style = (p < 5) ? key_style_t'(p) : key_style_t'($urandom_range(0, 4));
      load_key_pair(pick_key(style), pick_key(key_style_t'($urandom_range(0, 4))));
      if (p % 3 == 0) write_unused_reg();
      gaps_on = (p != 2);
      if (p == 4) hold_rx = 1'b1;
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (n == 0) restart = ($urandom_range(0, 99) < 85);
        else restart = ($urandom_range(0, 99) < 6);
        // sender pause until the pipeline is empty
        if (p == 6 && n == PHASE_WORDS / 2) wait_drained();
        send_byte(8'($urandom_range(0, 255)), restart);
      end
      wait_drained();
    end
    gaps_on = 1'b1;

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/tlfsr_pkg.sv
rtl/tlfsr_cfg.sv
rtl/tlfsr_core.sv
rtl/three_lfsr_combiner_stream_cipher.sv
rtl/tlfsr_checker.sv
test/tb_three_lfsr_combiner_stream_cipher.sv
